@@ sv/pfm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package pfm_pkg;

  localparam int FRAMES     = 16;
  localparam int ADDR_BITS  = 64;
  localparam int ADDR_W     = 64;
  localparam int PAGE_W     = 63;
  localparam int PHYS_W     = 36;
  localparam int FIDX_W     = 4;
  localparam int OFF_W      = 6;
  localparam int MAX_OFFSET = 32;
  localparam int FRAME_W    = $clog2(FRAMES);
  localparam int RANK_W     = FRAME_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 6;

  localparam logic [ADDR_W-1:0] ADDR_MASK = {ADDR_W{1'b1}} >> (ADDR_W - ADDR_BITS);
  localparam logic [OFF_W-1:0]  OFF_RESET = OFF_W'(12);
  localparam logic [OFF_W-1:0]  OFF_MAX   = OFF_W'(MAX_OFFSET);
  localparam logic [RANK_W-1:0] RANK_TOP  = RANK_W'(FRAMES - 1);
  localparam logic [FRAME_W-1:0] FRAME_LAST = FRAME_W'(FRAMES - 1);

  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_BITS = CFG_IDX_W'(1);

  localparam logic POLICY_FIFO = 1'b0;
  localparam logic POLICY_LRU  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_COMMIT
  } pfm_state_t;

  typedef struct packed {
    logic capture;
    logic search;
    logic commit;
  } pfm_cmd_t;

endpackage

`default_nettype wire

@@ sv/pfm_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfm_ctrl (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            start,
  output logic                 busy,
  output pfm_pkg::pfm_cmd_t    cmd
);
  import pfm_pkg::*;

  pfm_state_t state;
  pfm_state_t state_next;
  logic       accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    busy        = (state == ST_SEARCH);
    accept      = start && !busy;
    cmd.capture = accept;
    cmd.search  = (state == ST_SEARCH);
    cmd.commit  = (state == ST_COMMIT);
    state_next  = state;
    case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_SEARCH;
      end
      ST_SEARCH: begin
        state_next = ST_COMMIT;
      end
      ST_COMMIT: begin
        // overlap the table write with the next word's capture
        state_next = accept ? ST_SEARCH : ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ sv/pfm_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfm_datapath (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire pfm_pkg::pfm_cmd_t             cmd,
  input  wire logic                          cfg_we,
  input  wire logic [pfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pfm_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic [pfm_pkg::ADDR_W-1:0]     virt_address,
  output logic [pfm_pkg::PHYS_W-1:0]          phys_address,
  output logic                               hit,
  output logic [pfm_pkg::FIDX_W-1:0]          frame_index,
  output logic                               done
);
  import pfm_pkg::*;

  localparam int OFFW1 = MAX_OFFSET + 1;

  // configuration
  logic             policy;
  logic [OFF_W-1:0] offset_bits;
  logic [OFF_W-1:0] off_sat;

  // table state
  logic [PAGE_W-1:0]  frame_page [FRAMES];
  logic [FRAMES-1:0]  frame_valid;
  logic [RANK_W-1:0]  lru_rank [FRAMES];
  logic [FRAME_W-1:0] fifo_pointer;

  // captured word
  logic [PAGE_W-1:0]     page_q;
  logic [MAX_OFFSET-1:0] offset_q;

  // search results
  logic               hit_q;
  logic [FRAME_W-1:0] sel_q;
  logic [RANK_W-1:0]  sel_rank_q;

  logic [ADDR_W-1:0]     addr_m;
  logic [ADDR_W-1:0]     addr_shift;
  logic [OFFW1-1:0]      off_one;
  logic [MAX_OFFSET-1:0] off_mask;

  logic               match_found;
  logic [FRAME_W-1:0] match_frame;
  logic               empty_found;
  logic [FRAME_W-1:0] empty_frame;
  logic [FRAME_W-1:0] lru_frame;
  logic [FRAME_W-1:0] victim;
  logic [FRAME_W-1:0] sel_next;
  logic [ADDR_W-1:0]  phys_wide;

  assign off_sat    = (offset_bits > OFF_MAX) ? OFF_MAX : offset_bits;
  assign addr_m     = virt_address & ADDR_MASK;
  assign addr_shift = addr_m >> off_sat;
  assign off_one    = OFFW1'(1) << off_sat;
  assign off_mask   = MAX_OFFSET'(off_one - OFFW1'(1));
  assign phys_wide  = (ADDR_W'(sel_q) << off_sat) | ADDR_W'(offset_q);

  // associative compare, first free frame, least recent frame
  always_comb begin
    match_found = 1'b0;
    match_frame = '0;
    empty_found = 1'b0;
    empty_frame = '0;
    lru_frame   = '0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!match_found && frame_valid[i] && (frame_page[i] == page_q)) begin
        match_found = 1'b1;
        match_frame = FRAME_W'(i);
      end
      if (!empty_found && !frame_valid[i]) begin
        empty_found = 1'b1;
        empty_frame = FRAME_W'(i);
      end
      if (lru_rank[i] == '0) begin
        lru_frame = FRAME_W'(i);
      end
    end
    if (policy == POLICY_LRU) begin
      victim = empty_found ? empty_frame : lru_frame;
    end else begin
      victim = fifo_pointer;
    end
    sel_next = match_found ? match_frame : victim;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      policy       <= POLICY_FIFO;
      offset_bits  <= OFF_RESET;
      frame_valid  <= '0;
      fifo_pointer <= '0;
      done         <= 1'b0;
      for (int i = 0; i < FRAMES; i++) begin
        lru_rank[i] <= RANK_W'(i);
      end
    end else begin
      done <= cmd.commit;
      if (cfg_we) begin
        case (cfg_index)
          REG_POLICY:      policy      <= cfg_data[0];
          REG_OFFSET_BITS: offset_bits <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        if (!hit_q) begin
          frame_valid[sel_q] <= 1'b1;
          if (policy == POLICY_FIFO) begin
            fifo_pointer <= (sel_q == FRAME_LAST) ? '0 : sel_q + FRAME_W'(1);
          end
        end
        // touch: move the selected frame to most recent
        for (int i = 0; i < FRAMES; i++) begin
          if (FRAME_W'(i) == sel_q) begin
            lru_rank[i] <= RANK_TOP;
          end else if (lru_rank[i] > sel_rank_q) begin
            lru_rank[i] <= lru_rank[i] - RANK_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      page_q   <= addr_shift[PAGE_W-1:0];
      offset_q <= addr_m[MAX_OFFSET-1:0] & off_mask;
    end
    if (cmd.search) begin
      hit_q      <= match_found;
      sel_q      <= sel_next;
      sel_rank_q <= lru_rank[sel_next];
    end
    if (cmd.commit) begin
      if (!hit_q) begin
        frame_page[sel_q] <= page_q;
      end
      phys_address <= phys_wide[PHYS_W-1:0];
      hit          <= hit_q;
      frame_index  <= FIDX_W'(sel_q);
    end
  end

endmodule

`default_nettype wire

@@ sv/page_frame_map_fifo_lru.sv @@
// channel   handshake               payload
// input     start, busy             virt_address
// result    done (one-cycle strobe) phys_address, hit, frame_index
// config    cfg_valid, cfg_ready    cfg_index, cfg_data
//
// A word passes through the search state, for the associative compare over
// all frames, and then the commit state, for the table, recency and pointer
// update, which overlaps the capture of the next word. The result strobe is
// registered from the commit state. cfg_ready is always high.
// Reset clears valid bits, the FIFO pointer and the ranks (rank equals
// frame index); page tags are not reset. The receiver cannot stall.
`timescale 1ns / 1ps
`default_nettype none

module page_frame_map_fifo_lru (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [pfm_pkg::ADDR_W-1:0]     virt_address,
  output logic                               done,
  output logic [pfm_pkg::PHYS_W-1:0]          phys_address,
  output logic                               hit,
  output logic [pfm_pkg::FIDX_W-1:0]          frame_index,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [pfm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [pfm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import pfm_pkg::*;

  pfm_cmd_t cmd;

  assign cfg_ready = 1'b1;

  pfm_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  pfm_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .virt_address (virt_address),
    .phys_address (phys_address),
    .hit          (hit),
    .frame_index  (frame_index),
    .done         (done)
  );

endmodule

`default_nettype wire

@@ sv/pfm_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module pfm_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic start,
  input wire logic busy,
  input wire logic done
);

  // an accepted word blocks the next one while busy is high in the search state
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted word did not raise busy");

  a_busy_short: assert property (@(posedge clk) disable iff (rst)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  // every accepted word yields its strobe after the search and commit states
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##3 done)
    else $error("result strobe missing after accepted word");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe on two cycles in a row");

endmodule

bind page_frame_map_fifo_lru pfm_checker u_pfm_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done)
);

`default_nettype wire

@@ verif/tb_page_frame_map_fifo_lru.sv @@
`timescale 1ns / 1ps

module tb_page_frame_map_fifo_lru;
  import pfm_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int PHASES      = 10;
  localparam int PHASE_WORDS = 100;
  localparam int POOL_MAX    = 24;

  // index with no register behind it; a write there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

  typedef struct packed {
    logic [PHYS_W-1:0] phys;
    logic              hit;
    logic [FIDX_W-1:0] frame;
  } xlat_t;

  typedef enum logic {ROW_WORD, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic [ADDR_W-1:0]     addr;
    logic                  typed;
    xlat_t                 res;
  } row_t;

  localparam int NROWS = 23;

  localparam row_t DIR_ROWS [NROWS] = '{
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h0000_0000_0000_0000, 1'b1, '{36'h0_0000_0000, 1'b0, 4'd0}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h0000_0000_0000_0FFF, 1'b1, '{36'h0_0000_0FFF, 1'b1, 4'd0}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, '{36'h0_0000_1FFF, 1'b0, 4'd1}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h0000_0000_0000_1000, 1'b1, '{36'h0_0000_2000, 1'b0, 4'd2}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h0000_0000_0000_1ABC, 1'b1, '{36'h0_0000_2ABC, 1'b1, 4'd2}},
    // offset wider than the limit saturates to 32
    '{ROW_REG, REG_OFFSET_BITS, 6'd63, 64'h0, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'hFFFF_FFFF_0000_0000, 1'b1, '{36'h3_0000_0000, 1'b0, 4'd3}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h0000_0001_8000_0001, 1'b1, '{36'h2_8000_0001, 1'b1, 4'd2}},
    // empty offset: whole address is the page, top bit dropped
    '{ROW_REG, REG_OFFSET_BITS, 6'd0, 64'h0, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h8000_0000_0000_0001, 1'b1, '{36'h0_0000_0002, 1'b1, 4'd2}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h0000_0000_0000_0000, 1'b1, '{36'h0_0000_0000, 1'b1, 4'd0}},
    '{ROW_REG, REG_POLICY, 6'h3F, 64'h0, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h7FFF_FFFF_FFFF_FFFF, 1'b1, '{36'h0_0000_0004, 1'b0, 4'd4}},
    '{ROW_REG, REG_OFFSET_BITS, 6'd32, 64'h0, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_REG, REG_SPARE, 6'h2A, 64'h0, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h0000_0005_1234_5678, 1'b1, '{36'h5_1234_5678, 1'b0, 4'd5}},
    '{ROW_REG, REG_OFFSET_BITS, 6'd1, 64'h0, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'hAAAA_AAAA_AAAA_AAAB, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h5555_5555_5555_5554, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_REG, REG_OFFSET_BITS, 6'd12, 64'h0, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_REG, REG_POLICY, 6'd0, 64'h0, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h0000_0000_0003_0123, 1'b0, '{36'h0, 1'b0, 4'd0}},
    '{ROW_WORD, REG_POLICY, 6'd0, 64'h0000_0000_0000_1FFF, 1'b0, '{36'h0, 1'b0, 4'd0}}
  };

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  logic [ADDR_W-1:0]     virt_address;
  logic                  done;
  logic [PHYS_W-1:0]     phys_address;
  logic                  hit;
  logic [FIDX_W-1:0]     frame_index;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // shadow of the translation table
  logic [PAGE_W-1:0]  shadow_page [FRAMES];
  logic               shadow_valid [FRAMES];
  logic [RANK_W-1:0]  shadow_rank [FRAMES];
  logic [FRAME_W-1:0] fifo_next;
  logic               cur_policy;
  logic [OFF_W-1:0]   cur_offset;

  xlat_t       pending_xlat [$];
  logic [63:0] page_pool [POOL_MAX];
  int          mismatches;
  int          words_sent;
  int          xlats_seen;
  int          hits_seen;
  int          reg_writes;
  int          quiet_cycles;

  page_frame_map_fifo_lru u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .virt_address (virt_address),
    .done         (done),
    .phys_address (phys_address),
    .hit          (hit),
    .frame_index  (frame_index),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int unsigned page_shift();
    return (cur_offset > MAX_OFFSET) ? MAX_OFFSET : int'(cur_offset);
  endfunction

  // translate one address against the shadow table and update it
  function automatic xlat_t map_lookup(input logic [ADDR_W-1:0] va);
    int unsigned sh;
    int          victim;
    bit          found;
    logic [63:0] ofs;
    logic [63:0] pg;
    logic [RANK_W-1:0] r;
    xlat_t       res;
    sh = page_shift();
    ofs = va & ((64'd1 << sh) - 64'd1);
    pg = va >> sh;
    found = 1'b0;
    victim = 0;
    for (int i = 0; i < FRAMES; i++) begin
      if (!found && shadow_valid[i] && shadow_page[i] == pg[PAGE_W-1:0]) begin
        found = 1'b1;
        victim = i;
      end
    end
    res.hit = found;
    if (!found) begin
      if (cur_policy == POLICY_FIFO) begin
        victim = int'(fifo_next);
        fifo_next = FRAME_W'((victim + 1) % FRAMES);
      end else begin
        // lowest empty frame first, else the least recent one
        for (int i = 0; i < FRAMES; i++) begin
          if (!found && !shadow_valid[i]) begin
            found = 1'b1;
            victim = i;
          end
        end
        if (!found) begin
          for (int i = 0; i < FRAMES; i++) begin
            if (shadow_rank[i] < shadow_rank[victim]) victim = i;
          end
        end
      end
      shadow_page[victim] = pg[PAGE_W-1:0];
      shadow_valid[victim] = 1'b1;
    end
    // ranks move under either policy
    r = shadow_rank[victim];
    for (int i = 0; i < FRAMES; i++) begin
      if (shadow_rank[i] > r) shadow_rank[i] = shadow_rank[i] - 1'b1;
    end
    shadow_rank[victim] = RANK_TOP;
    res.frame = FIDX_W'(victim);
    res.phys = PHYS_W'((64'(victim) << sh) | ofs);
    return res;
  endfunction

  // hold new words off until the table is quiet, then write one register
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    start <= 1'b0;
    while (pending_xlat.size() != 0) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_POLICY) cur_policy = val[0];
    else if (idx == REG_OFFSET_BITS) cur_offset = val;
    reg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_word(input logic [ADDR_W-1:0] va, input logic typed,
                           input xlat_t typed_res, input bit calm);
    int    gap;
    int    roll;
    xlat_t pred;
    roll = $urandom_range(0, 99);
    if (calm || roll < 65) gap = 0;
    else if (roll < 92) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    virt_address <= va;
    do @(posedge clk); while (busy);
    pred = map_lookup(va);
    pending_xlat.push_back(typed ? typed_res : pred);
    words_sent++;
  endtask

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  always @(posedge clk) begin
    xlat_t got;
    xlat_t want;
    if (!rst && done) begin
      got.phys = phys_address;
      got.hit = hit;
      got.frame = frame_index;
      xlats_seen++;
      if (hit) hits_seen++;
      if (pending_xlat.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("ERROR: unexpected word phys=%h hit=%b frame=%0d",
                   got.phys, got.hit, got.frame);
      end else begin
        want = pending_xlat.pop_front();
        if (got.phys !== want.phys || got.hit !== want.hit || got.frame !== want.frame) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: word %0d expected phys=%h hit=%b frame=%0d, got phys=%h hit=%b frame=%0d",
                     xlats_seen, want.phys, want.hit, want.frame,
                     got.phys, got.hit, got.frame);
        end
      end
    end
  end

  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("ERROR: no progress for %0d cycles, %0d words still due",
             QUIET_LIMIT, pending_xlat.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int          pool_n;
    int unsigned sh;
    bit          calm;
    logic [63:0] va;
    logic [CFG_DATA_W-1:0] off_sel;
    rst = 1'b1;
    start = 1'b0;
    virt_address = '0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    mismatches = 0;
    words_sent = 0;
    xlats_seen = 0;
    hits_seen = 0;
    reg_writes = 0;
    quiet_cycles = 0;
    for (int i = 0; i < FRAMES; i++) begin
      shadow_page[i] = '0;
      shadow_valid[i] = 1'b0;
      shadow_rank[i] = RANK_W'(i);
    end
    fifo_next = '0;
    cur_policy = POLICY_FIFO;
    cur_offset = OFF_RESET;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (DIR_ROWS[n]) begin
      if (DIR_ROWS[n].kind == ROW_REG) write_reg(DIR_ROWS[n].idx, DIR_ROWS[n].data);
      else send_word(DIR_ROWS[n].addr, DIR_ROWS[n].typed, DIR_ROWS[n].res, 1'b0);
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: off_sel = 6'd12;
        1: off_sel = 6'd0;
        2: off_sel = 6'd63;
        3: off_sel = 6'd32;
        4: off_sel = 6'd1;
        5: off_sel = CFG_DATA_W'($urandom_range(33, 62));
        default: off_sel = CFG_DATA_W'($urandom_range(2, 31));
      endcase
      write_reg(REG_POLICY, {CFG_DATA_W'($urandom_range(0, 31)) << 1} | CFG_DATA_W'(ph % 2));
      write_reg(REG_OFFSET_BITS, off_sel);
      sh = page_shift();
      // a small pool stays resident, a large one forces evictions
      pool_n = $urandom_range(4, POOL_MAX);
      for (int k = 0; k < pool_n; k++) page_pool[k] = {$urandom, $urandom};
      calm = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (ph == 3 && k == PHASE_WORDS / 2) begin
          start <= 1'b0;
          while (pending_xlat.size() != 0) @(posedge clk);
        end
        if ($urandom_range(0, 9) == 0) va = {$urandom, $urandom};
        else va = (page_pool[$urandom_range(0, pool_n - 1)] << sh)
                  | ({$urandom, $urandom} & ((64'd1 << sh) - 64'd1));
        send_word(va, 1'b0, '0, calm);
      end
    end
    start <= 1'b0;

    while (pending_xlat.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("Translated %0d words (%0d hits, %0d faults) across %0d register writes.",
             xlats_seen, hits_seen, xlats_seen - hits_seen, reg_writes);
    $display("Both replacement policies, offsets 0 through 63, %0d mismatches.", mismatches);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
